// ----- hw/rtl/mfrc_pkg.sv -----
// ----------------------------------------------------------------------------
// mfrc_pkg
// Shared types and constants of the multiplexed frame receive classifier.
// ----------------------------------------------------------------------------
package mfrc_pkg;

  localparam logic [15:0] CONTROL_LIMIT = 16'd1024;
  localparam logic [15:0] RECEIVE_LIMIT = 16'd16384;

  localparam logic [7:0] CMD_PSH             = 8'd2;
  localparam logic [7:0] CMD_FIN             = 8'd3;
  localparam logic [7:0] CMD_ALERT           = 8'd5;
  localparam logic [7:0] CMD_SYNACK          = 8'd7;
  localparam logic [7:0] CMD_HEART_REQUEST   = 8'd8;
  localparam logic [7:0] CMD_SERVER_SETTINGS = 8'd10;

  // index of the final header byte (header is seven bytes)
  localparam logic [2:0] HDR_LAST_IDX = 3'd6;

  typedef enum logic [1:0] {
    PH_HANDSHAKE = 2'd0,
    PH_OPEN      = 2'd1,
    PH_STOPPED   = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    EV_DATA   = 3'd0,
    EV_HEART  = 3'd1,
    EV_OPEN   = 3'd2,
    EV_CLOSED = 3'd3,
    EV_ERROR  = 3'd4
  } event_e;

  typedef enum logic [2:0] {
    ERR_ALERT     = 3'd0,
    ERR_OVERSIZE  = 3'd1,
    ERR_REJECTED  = 3'd2,
    ERR_EARLY     = 3'd3,
    ERR_TOO_LARGE = 3'd4
  } err_e;

  typedef struct packed {
    logic        emit;
    event_e      ev;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [31:0] frame_id;
    err_e        error_code;
  } result_t;

endpackage

// ----- hw/rtl/mfrc_parser.sv -----
// ----------------------------------------------------------------------------
// mfrc_parser
// Frame state and per-byte classification: header assembly, payload count,
// handshake/open phase rules. One byte is processed per fire.
// ----------------------------------------------------------------------------
module mfrc_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  logic [7:0]          byte_i,
  input  logic [31:0]         local_id_i,
  output mfrc_pkg::result_t   res_o
);

  typedef struct packed {
    logic           emit;
    mfrc_pkg::event_e ev;
    mfrc_pkg::err_e   err;
    logic           heart;
    logic           go_open;
    logic           stop;
    logic           set_seen;
  } finish_t;

  mfrc_pkg::phase_e phase_q, phase_d;
  logic        seen_q, seen_d;
  logic [2:0]  hidx_q, hidx_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [31:0] stream_q, stream_d;
  logic [15:0] len_q, len_d;
  logic [15:0] left_q, left_d;
  logic        big_q, big_d;

  function automatic finish_t finish_frame(mfrc_pkg::phase_e ph, logic seen,
                                           logic [7:0] cmd, logic hit,
                                           logic len_nz, logic big);
    finish_t f;
    f = '0;
    if (ph == mfrc_pkg::PH_HANDSHAKE) begin
      if (big) begin
        f.emit = 1'b1; f.ev = mfrc_pkg::EV_ERROR; f.err = mfrc_pkg::ERR_OVERSIZE;
        f.stop = 1'b1;
      end else begin
        case (cmd)
          mfrc_pkg::CMD_SERVER_SETTINGS: f.set_seen = 1'b1;
          mfrc_pkg::CMD_SYNACK: begin
            if (hit && len_nz) begin
              f.emit = 1'b1; f.ev = mfrc_pkg::EV_ERROR;
              f.err = mfrc_pkg::ERR_REJECTED; f.stop = 1'b1;
            end else if (hit) begin
              f.emit = 1'b1; f.ev = mfrc_pkg::EV_OPEN; f.go_open = 1'b1;
            end
          end
          mfrc_pkg::CMD_HEART_REQUEST: begin
            f.emit = 1'b1; f.ev = mfrc_pkg::EV_HEART; f.heart = 1'b1;
          end
          mfrc_pkg::CMD_ALERT: begin
            f.emit = 1'b1; f.ev = mfrc_pkg::EV_ERROR; f.err = mfrc_pkg::ERR_ALERT;
            f.stop = 1'b1;
          end
          mfrc_pkg::CMD_PSH: begin
            if (!seen && hit) begin
              f.emit = 1'b1; f.ev = mfrc_pkg::EV_ERROR;
              f.err = mfrc_pkg::ERR_EARLY; f.stop = 1'b1;
            end
          end
          default: f.emit = 1'b0;
        endcase
      end
    end else if (ph == mfrc_pkg::PH_OPEN) begin
      if (cmd == mfrc_pkg::CMD_FIN && hit) begin
        f.emit = 1'b1; f.ev = mfrc_pkg::EV_CLOSED; f.stop = 1'b1;
      end else if (big) begin
        if (cmd == mfrc_pkg::CMD_ALERT) begin
          f.emit = 1'b1; f.ev = mfrc_pkg::EV_ERROR; f.err = mfrc_pkg::ERR_ALERT;
          f.stop = 1'b1;
        end
      end else begin
        case (cmd)
          mfrc_pkg::CMD_HEART_REQUEST: begin
            f.emit = 1'b1; f.ev = mfrc_pkg::EV_HEART; f.heart = 1'b1;
          end
          mfrc_pkg::CMD_SYNACK: begin
            if (hit && len_nz) begin
              f.emit = 1'b1; f.ev = mfrc_pkg::EV_ERROR;
              f.err = mfrc_pkg::ERR_REJECTED; f.stop = 1'b1;
            end
          end
          mfrc_pkg::CMD_ALERT: begin
            f.emit = 1'b1; f.ev = mfrc_pkg::EV_ERROR; f.err = mfrc_pkg::ERR_ALERT;
            f.stop = 1'b1;
          end
          default: f.emit = 1'b0;
        endcase
      end
    end
    return f;
  endfunction

  logic        active;
  logic        hit_cur, hit_new;
  logic        local_data_cur, local_data_new;
  logic [15:0] left_dec;
  logic [31:0] stream_new;
  logic [15:0] len_new;
  logic [7:0]  cmd_new;
  finish_t     fin;
  logic        fin_use;
  logic [31:0] fin_stream;

  always_comb begin
    active   = (phase_q == mfrc_pkg::PH_HANDSHAKE) || (phase_q == mfrc_pkg::PH_OPEN);
    hit_cur  = (stream_q == local_id_i);
    local_data_cur = (phase_q == mfrc_pkg::PH_OPEN) && (cmd_q == mfrc_pkg::CMD_PSH)
                     && hit_cur;
    left_dec = left_q - 16'd1;

    // header assembly for this byte
    cmd_new    = cmd_q;
    stream_new = stream_q;
    len_new    = len_q;
    unique case (hidx_q)
      3'd0: begin
        cmd_new    = byte_i;
        stream_new = '0;
        len_new    = '0;
      end
      3'd1, 3'd2, 3'd3, 3'd4: stream_new = {stream_q[23:0], byte_i};
      default: len_new = {len_q[7:0], byte_i};
    endcase
    hit_new        = (stream_new == local_id_i);
    local_data_new = (phase_q == mfrc_pkg::PH_OPEN) && (cmd_new == mfrc_pkg::CMD_PSH)
                     && hit_new;

    // frame-end action: end of payload uses stored header, empty frame the new one
    fin_use = 1'b0;
    if (left_q != 16'd0) begin
      fin        = finish_frame(phase_q, seen_q, cmd_q, hit_cur, len_q != 16'd0, big_q);
      fin_stream = stream_q;
    end else begin
      fin        = finish_frame(phase_q, seen_q, cmd_new, hit_new, 1'b0, 1'b0);
      fin_stream = stream_new;
    end

    phase_d  = phase_q;
    seen_d   = seen_q;
    hidx_d   = hidx_q;
    cmd_d    = cmd_q;
    stream_d = stream_q;
    len_d    = len_q;
    left_d   = left_q;
    big_d    = big_q;
    res_o    = '0;

    if (fire_i && active) begin
      if (left_q != 16'd0) begin
        left_d = left_dec;
        if (local_data_cur) begin
          res_o.emit      = 1'b1;
          res_o.ev        = mfrc_pkg::EV_DATA;
          res_o.data_byte = byte_i;
          res_o.last_byte = (left_dec == 16'd0);
        end else if (left_dec == 16'd0) begin
          fin_use = 1'b1;
        end
      end else begin
        cmd_d    = cmd_new;
        stream_d = stream_new;
        len_d    = len_new;
        if (hidx_q != mfrc_pkg::HDR_LAST_IDX) begin
          hidx_d = hidx_q + 3'd1;
        end else begin
          hidx_d = '0;
          big_d  = (len_new > mfrc_pkg::CONTROL_LIMIT);
          if (local_data_new) begin
            if (len_new > mfrc_pkg::RECEIVE_LIMIT) begin
              res_o.emit       = 1'b1;
              res_o.ev         = mfrc_pkg::EV_ERROR;
              res_o.error_code = mfrc_pkg::ERR_TOO_LARGE;
              phase_d          = mfrc_pkg::PH_STOPPED;
            end else begin
              left_d = len_new;
            end
          end else if (len_new != 16'd0) begin
            left_d = len_new;
          end else begin
            fin_use = 1'b1;
          end
        end
      end

      if (fin_use) begin
        res_o.emit       = fin.emit;
        res_o.ev         = fin.ev;
        res_o.error_code = fin.err;
        res_o.frame_id   = fin.heart ? fin_stream : 32'd0;
        if (fin.set_seen) seen_d  = 1'b1;
        if (fin.go_open)  phase_d = mfrc_pkg::PH_OPEN;
        if (fin.stop)     phase_d = mfrc_pkg::PH_STOPPED;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= mfrc_pkg::PH_HANDSHAKE;
      seen_q   <= 1'b0;
      hidx_q   <= '0;
      cmd_q    <= '0;
      stream_q <= '0;
      len_q    <= '0;
      left_q   <= '0;
      big_q    <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      seen_q   <= seen_d;
      hidx_q   <= hidx_d;
      cmd_q    <= cmd_d;
      stream_q <= stream_d;
      len_q    <= len_d;
      left_q   <= left_d;
      big_q    <= big_d;
    end
  end

endmodule

// ----- hw/rtl/mfrc_out_stage.sv -----
// ----------------------------------------------------------------------------
// mfrc_out_stage
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module mfrc_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  mfrc_pkg::result_t res_i,
  input  logic              ready_i,
  output logic              space_o,
  output logic              valid_o,
  output mfrc_pkg::result_t res_o
);

  logic              valid_q, valid_d;
  mfrc_pkg::result_t res_q;

  assign space_o = !valid_q || ready_i;
  assign valid_d = load_i ? 1'b1 : (valid_q && !ready_i);
  assign valid_o = valid_q;
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

// ----- hw/rtl/mux_frame_receive_classifier.sv -----
// Path: input register, parser, then result register for the result, if any.
// Throughput: one byte per cycle while the result side keeps up; a stalled result
//   holds the parser, and the input register then takes at most one more byte.
// Reset (rst_ni low, asynchronous): handshake phase, empty header, no payload
//   pending, both stages empty, local stream id back to 1.
// ----------------------------------------------------------------------------
// mux_frame_receive_classifier
// Receive-side classifier for a multiplexed frame stream: parses the seven
// byte header, counts payload, and reports data, heartbeat, open, close and
// error events.
// ----------------------------------------------------------------------------
module mux_frame_receive_classifier (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: local stream id
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  // received bytes
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] byte_in
  // classified events
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // [7:0] data_byte, [39:8] frame_id,
                                        // [42:40] error_code, [47:43] zero
  output logic        m_axis_tlast_o,   // last_byte
  output logic [2:0]  m_axis_tuser_o    // [2:0] event_res
);

  // Local stream id, compared against the header stream id.
  logic [31:0] local_id_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_id_q <= 32'd1;
    end else if (cfg_we_i) begin
      local_id_q <= cfg_wdata_i;
    end
  end

  // Input register: one byte held ahead of the parser.
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       out_space;
  logic       fire;
  logic       in_take;

  assign fire            = in_valid_q && out_space;
  assign s_axis_tready_o = !in_valid_q || out_space;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;
  assign in_valid_d      = in_take ? 1'b1 : (in_valid_q && !fire);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= s_axis_tdata_i;
    end
  end

  // Parser: consumes the held byte whenever the result register has room.
  mfrc_pkg::result_t parse_res;
  mfrc_pkg::result_t out_res;

  mfrc_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .byte_i     (in_byte_q),
    .local_id_i (local_id_q),
    .res_o      (parse_res)
  );

  // Result register; bytes that give no event simply do not load it.
  mfrc_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (fire && parse_res.emit),
    .res_i   (parse_res),
    .ready_i (m_axis_tready_i),
    .space_o (out_space),
    .valid_o (m_axis_tvalid_o),
    .res_o   (out_res)
  );

  assign m_axis_tdata_o = {5'd0, out_res.error_code, out_res.frame_id, out_res.data_byte};
  assign m_axis_tlast_o = out_res.last_byte;
  assign m_axis_tuser_o = out_res.ev;

endmodule

// ----- hw/rtl/mfrc_checker.sv -----
// ----------------------------------------------------------------------------
// mfrc_checker
// Port-level checks of the classifier's result channel, bound to the top.
// ----------------------------------------------------------------------------
module mfrc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [47:0] m_axis_tdata_o,
  input logic        m_axis_tlast_o,
  input logic [2:0]  m_axis_tuser_o
);

  // a stalled transaction stays offered
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result dropped while stalled");

  // tlast only marks payload bytes
  a_last_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o != mfrc_pkg::EV_DATA) |-> !m_axis_tlast_o)
    else $error("tlast on a non-data event");

  // frame id only carried by heartbeat events
  a_id_heart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o != mfrc_pkg::EV_HEART)
      |-> (m_axis_tdata_o[39:8] == 32'd0))
    else $error("frame id on a non-heartbeat event");

  // error code zero unless the event is an error; data byte zero unless data
  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o != mfrc_pkg::EV_ERROR)
      |-> (m_axis_tdata_o[42:40] == 3'd0))
    else $error("error code on a non-error event");

  a_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o != mfrc_pkg::EV_DATA)
      |-> (m_axis_tdata_o[7:0] == 8'd0))
    else $error("data byte on a non-data event");

endmodule

bind mux_frame_receive_classifier mfrc_checker u_mfrc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
